@@ hw/rtl/websocket_frame_deframer_macros.svh @@
// Assertion macros used by the deframer request queue module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define WSD_ASSERT(lbl, prop, msg)
`define WSD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

    localparam logic [15:0] CAP_RESET  = 16'd1500;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_STOPPED = 3'd6
    } phase_t;

    // The first five codes are also the kind codes seen at the output.
    typedef enum logic [2:0] {
        CLS_TEXT      = 3'd0,
        CLS_PING      = 3'd1,
        CLS_CLOSE     = 3'd2,
        CLS_OTHER     = 3'd3,
        CLS_TOO_LARGE = 3'd4,
        CLS_PONG      = 3'd5
    } cls_t;

    // One queued request from the parser to the output side.
    typedef struct packed {
        cls_t        kind;
        logic [7:0]  raw;
        logic [7:0]  key;
        logic        has_data;
        logic        last;
    } cmd_t;

    function automatic cls_t classify(input logic fin, input logic [3:0] opcode);
        cls_t c;
        if (opcode == OP_TEXT && fin)
            c = CLS_TEXT;
        else if (opcode == OP_PING)
            c = CLS_PING;
        else if (opcode == OP_PONG)
            c = CLS_PONG;
        else if (opcode == OP_CLOSE)
            c = CLS_CLOSE;
        else
            c = CLS_OTHER;
        return c;
    endfunction

endpackage

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// WebSocket receive deframer.
// Input channel rx_valid/rx_ready/rx_byte takes one received byte per cycle while rx_ready is high.
// Output channel out_valid/out_ready carries kind, data_byte, has_data and last:
// unmasked payload bytes of final text frames and of ping frames, an empty-payload
// marker, or a close, unsupported or too-large event with last set.
// cfg_wr_en/cfg_wr_data write the frame capacity (header plus payload bytes);
// write it only while the block is idle.
// Throughput is one byte per cycle while the queue has room. A result is first written into
// the request queue and then loaded into the output register once that register is free
// or being taken.
// The four-entry request queue and the output register absorb output stalls; rx_ready
// falls only when the queue is full, so a stalled receiver holds back the input after
// five requests.
// Reset clears the parser to expect a new frame header, empties the queue and
// restores a capacity of 1500. After a close, unsupported or too-large event all
// further bytes are accepted and dropped until the next reset.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        last
);

    logic [15:0] cap_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    cmd_t        q_cmd;
    cmd_t        q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

    wsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .capacity (cap_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    wsd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .has_data  (has_data),
        .last      (last)
    );

endmodule

@@ hw/rtl/wsd_front.sv @@
`timescale 1ns / 1ps

module wsd_front
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] capacity,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    phase_t      phase_reg, phase_next;
    cls_t        cls_reg, cls_next;
    logic        masked_reg, masked_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  key_reg [4];
    logic [7:0]  key_next [4];
    logic [1:0]  kidx_reg, kidx_next;
    logic [3:0]  hdr_reg, hdr_next;

    logic        accept;
    logic [6:0]  n0;
    logic        ext_phase;
    logic        ext_last;
    logic        hdr1_short;
    logic        masked_now;
    logic [15:0] len_now;
    logic        ovf_now;
    logic [3:0]  hdr_now;
    logic        len_done;
    logic        hdr_end;
    logic [16:0] room;
    logic        too_large;
    logic        done;
    logic        streamed;

    assign rx_ready   = !q_full;
    assign accept     = rx_valid && !q_full;
    assign n0         = rx_byte[6:0];
    assign ext_phase  = (phase_reg == PH_EXT16) || (phase_reg == PH_EXT64);
    assign ext_last   = (phase_reg == PH_EXT16 && cnt_reg == 3'd1)
                     || (phase_reg == PH_EXT64 && cnt_reg == 3'd7);
    assign hdr1_short = (phase_reg == PH_HDR1) && (n0 != LEN_EXT16) && (n0 != LEN_EXT64);
    assign masked_now = (phase_reg == PH_HDR1) ? rx_byte[7] : masked_reg;
    assign len_done   = hdr1_short || (ext_phase && ext_last);
    assign done       = (rem_reg == 16'd1);
    assign streamed   = (cls_reg == CLS_TEXT) || (cls_reg == CLS_PING);

    // Length and header size as they stand once the current byte is taken.
    always_comb
    begin
        len_now = len_reg;
        ovf_now = ovf_reg;
        hdr_now = 4'(hdr_reg + 4'd1);
        if (phase_reg == PH_HDR1)
        begin
            len_now = {9'd0, n0};
            ovf_now = 1'b0;
            hdr_now = 4'd2;
        end
        else if (ext_phase)
        begin
            // Bits shifted past sixteen can only make the frame too large.
            len_now = {len_reg[7:0], rx_byte};
            ovf_now = ovf_reg || (len_reg[15:8] != 8'd0);
        end
    end

    assign hdr_end = accept && ((len_done && !masked_now)
                     || (phase_reg == PH_KEY && cnt_reg[1:0] == 2'd3));
    assign room      = {1'b0, capacity} - {13'd0, hdr_now};
    assign too_large = ovf_now || room[16] || ({1'b0, len_now} > room);

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        cls_next    = cls_reg;
        masked_next = masked_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        hdr_next    = hdr_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    cls_next   = classify(rx_byte[7], rx_byte[3:0]);
                    hdr_next   = 4'd1;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    hdr_next    = hdr_now;
                    cnt_next    = 3'd0;
                    ovf_next    = 1'b0;
                    if (n0 == LEN_EXT16)
                    begin
                        len_next   = 16'd0;
                        phase_next = PH_EXT16;
                    end
                    else if (n0 == LEN_EXT64)
                    begin
                        len_next   = 16'd0;
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        len_next = len_now;
                        if (rx_byte[7])
                            phase_next = PH_KEY;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next = len_now;
                    ovf_next = ovf_now;
                    hdr_next = hdr_now;
                    if (ext_last)
                    begin
                        cnt_next = 3'd0;
                        if (masked_reg)
                            phase_next = PH_KEY;
                    end
                    else
                        cnt_next = 3'(cnt_reg + 3'd1);
                end
                PH_KEY:
                begin
                    key_next[cnt_reg[1:0]] = rx_byte;
                    hdr_next = hdr_now;
                    if (cnt_reg[1:0] == 2'd3)
                        cnt_next = 3'd0;
                    else
                        cnt_next = 3'(cnt_reg + 3'd1);
                end
                PH_PAYLOAD:
                begin
                    kidx_next = 2'(kidx_reg + 2'd1);
                    rem_next  = 16'(rem_reg - 16'd1);
                    if (done)
                    begin
                        if (streamed || cls_reg == CLS_PONG)
                            phase_next = PH_HDR0;
                        else
                            phase_next = PH_STOPPED;
                    end
                end
                PH_STOPPED:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (hdr_end)
        begin
            if (too_large)
                phase_next = PH_STOPPED;
            else
            begin
                rem_next  = len_now;
                kidx_next = 2'd0;
                cnt_next  = 3'd0;
                if (len_now != 16'd0)
                    phase_next = PH_PAYLOAD;
                else if (cls_reg == CLS_CLOSE || cls_reg == CLS_OTHER)
                    phase_next = PH_STOPPED;
                else
                    phase_next = PH_HDR0;
            end
        end
    end

    // Requests toward the queue.
    always_comb
    begin
        q_push          = 1'b0;
        q_cmd.kind      = cls_reg;
        q_cmd.raw       = 8'd0;
        q_cmd.key       = 8'd0;
        q_cmd.has_data  = 1'b0;
        q_cmd.last      = 1'b1;
        if (hdr_end)
        begin
            if (too_large)
            begin
                q_push     = 1'b1;
                q_cmd.kind = CLS_TOO_LARGE;
            end
            else if (len_now == 16'd0 && cls_reg != CLS_PONG)
                q_push = 1'b1;
        end
        else if (accept && phase_reg == PH_PAYLOAD)
        begin
            if (streamed)
            begin
                q_push         = 1'b1;
                q_cmd.raw      = rx_byte;
                q_cmd.key      = masked_reg ? key_reg[kidx_reg] : 8'd0;
                q_cmd.has_data = 1'b1;
                q_cmd.last     = done;
            end
            else if (done && cls_reg != CLS_PONG)
                q_push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cls_reg    <= CLS_OTHER;
            masked_reg <= 1'b0;
            cnt_reg    <= 3'd0;
            len_reg    <= 16'd0;
            ovf_reg    <= 1'b0;
            rem_reg    <= 16'd0;
            kidx_reg   <= 2'd0;
            hdr_reg    <= 4'd0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cls_reg    <= cls_next;
            masked_reg <= masked_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            rem_reg    <= rem_next;
            kidx_reg   <= kidx_next;
            hdr_reg    <= hdr_next;
            key_reg    <= key_next;
        end
    end

endmodule

@@ hw/rtl/wsd_fifo.sv @@
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_fifo
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam logic [FIFO_AW:0] DEPTH_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = (FIFO_AW + 1)'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = (FIFO_AW + 1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    `WSD_ASSERT(a_no_push_full, !(push && full), "request pushed into a full queue")
    `WSD_ASSERT(a_no_pop_empty, !(pop && empty), "request popped from an empty queue")
    `WSD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "queue count out of range")

endmodule

@@ hw/rtl/wsd_back.sv @@
`timescale 1ns / 1ps

module wsd_back
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic       last
);

    logic       valid_reg, valid_next;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic       has_reg;
    logic       last_reg;

    // A new request moves up whenever the output register is free or being taken.
    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= head.kind;
            data_reg <= head.has_data ? (head.raw ^ head.key) : 8'd0;
            has_reg  <= head.has_data;
            last_reg <= head.last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign data_byte = data_reg;
    assign has_data  = has_reg;
    assign last      = last_reg;

endmodule
